### hw/rtl/lpss_pkg.sv
// Shared types for the lift and place safety supervisor.
`default_nettype none

package lpss_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_LEVEL_ANGLE = 2'd0;
    localparam logic [1:0] REG_TILT_LIMIT  = 2'd1;
    localparam logic [1:0] REG_BATTERY_MIN = 2'd2;

    // Pick-up detector phases.
    typedef enum logic [2:0] {
        LIFT_STILL = 3'b001,
        LIFT_SPIKE = 3'b010,
        LIFT_SPIN  = 3'b100
    } lift_phase_t;

    // Put-down detector phases.
    typedef enum logic [1:0] {
        PLACE_LEVEL = 2'b01,
        PLACE_TURN  = 2'b10
    } place_phase_t;

    // One control tick as it arrives on the input stream.
    typedef struct packed {
        logic signed [15:0] accel_z;
        logic signed [15:0] tilt_angle;
        logic signed [15:0] left_count;
        logic signed [15:0] right_count;
        logic        [15:0] battery_level;
        logic               toggle_stop;
    } lpss_item_t;

    // Configuration register values.
    typedef struct packed {
        logic signed [15:0] level_angle;
        logic        [14:0] tilt_limit;
        logic        [15:0] battery_min;
    } lpss_cfg_t;

    // Supervisor state carried from tick to tick.
    typedef struct packed {
        logic         stop_flag;
        lift_phase_t  lift_phase;
        logic [3:0]   still_count;
        logic [7:0]   lift_wait_count;
        logic [6:0]   spin_wait_count;
        place_phase_t place_phase;
        logic [5:0]   place_wait_count;
        logic [9:0]   mode_turn_sum;
        logic         avoid_flag;
        logic         follow_flag;
    } lpss_state_t;

    // Flags reported for one tick.
    typedef struct packed {
        logic stopped;
        logic picked_up;
        logic set_down;
        logic avoid_mode;
        logic follow_mode;
        logic drive_enable;
    } lpss_result_t;

endpackage

`default_nettype wire

### hw/rtl/lpss_core.sv
// Next-state and result logic for one control tick of the supervisor.
`default_nettype none

module lpss_core (
    input  var lpss_pkg::lpss_state_t  state,
    input  var lpss_pkg::lpss_item_t   item,
    input  var lpss_pkg::lpss_cfg_t    cfg,
    output lpss_pkg::lpss_state_t      state_next,
    output lpss_pkg::lpss_result_t     result
);

    localparam logic signed [15:0] LIFT_ACCEL_MIN = 16'sd26000;
    localparam logic        [16:0] STILL_SUM_MAX  = 17'd30;
    localparam logic        [3:0]  STILL_TICKS    = 4'd10;
    localparam logic        [7:0]  LIFT_TIMEOUT   = 8'd200;
    localparam logic        [6:0]  SPIN_TIMEOUT   = 7'd100;
    localparam logic signed [16:0] SPIN_SUM_MIN   = 17'sd70;
    localparam logic signed [17:0] LIFT_WINDOW    = 18'sd2000;
    localparam logic signed [17:0] PLACE_WINDOW   = 18'sd1000;
    localparam logic        [5:0]  PLACE_TIMEOUT  = 6'd50;
    localparam logic signed [15:0] PLACE_TURN_MIN = 16'sd3;
    localparam logic signed [15:0] PLACE_TURN_MAX = 16'sd40;
    localparam logic signed [15:0] MODE_HOLD_MAX  = 16'sd10;
    localparam logic        [16:0] MODE_NORMAL_LO = 17'd6;
    localparam logic        [16:0] MODE_AVOID_LO  = 17'd180;
    localparam logic        [16:0] MODE_FOLLOW_LO = 17'd360;
    localparam logic        [16:0] MODE_WRAP      = 17'd540;

    always_comb
    begin
        lpss_pkg::lpss_state_t st;
        logic               stop;
        logic               lifted;
        logic               placed;
        logic               fault;
        logic [15:0]        mag_l;
        logic [15:0]        mag_r;
        logic [16:0]        still_sum;
        logic signed [16:0] lr_sum;
        logic               spin_seen;
        logic signed [17:0] tilt_w;
        logic signed [17:0] level_w;
        logic               lift_win;
        logic               place_win;
        logic               turn_seen;
        logic [16:0]        mode_sum;
        logic signed [16:0] tilt_n;
        logic signed [16:0] limit_n;

        st = state;

        // Magnitudes and sums of the wheel counts, wide enough never to wrap.
        mag_l     = item.left_count[15]  ? 16'(-item.left_count)  : 16'(item.left_count);
        mag_r     = item.right_count[15] ? 16'(-item.right_count) : 16'(item.right_count);
        still_sum = {1'b0, mag_l} + {1'b0, mag_r};
        lr_sum    = {item.left_count[15], item.left_count}
                  + {item.right_count[15], item.right_count};
        spin_seen = (lr_sum > SPIN_SUM_MIN) || (lr_sum < -SPIN_SUM_MIN);

        // Tilt windows around the balance point.
        tilt_w    = {{2{item.tilt_angle[15]}}, item.tilt_angle};
        level_w   = {{2{cfg.level_angle[15]}}, cfg.level_angle};
        lift_win  = (tilt_w > level_w - LIFT_WINDOW) && (tilt_w < level_w + LIFT_WINDOW);
        place_win = (tilt_w > level_w - PLACE_WINDOW) && (tilt_w < level_w + PLACE_WINDOW);
        turn_seen = (item.left_count > PLACE_TURN_MIN) && (item.right_count > PLACE_TURN_MIN)
                 && (item.left_count < PLACE_TURN_MAX) && (item.right_count < PLACE_TURN_MAX);

        // Key click toggles the stop flag first.
        stop = st.stop_flag ^ item.toggle_stop;

        // Pick-up detector; a phase entered this tick is evaluated this tick too.
        lifted = 1'b0;
        if (st.lift_phase == lpss_pkg::LIFT_STILL)
        begin
            if (still_sum < STILL_SUM_MAX)
                st.still_count = st.still_count + 4'd1;
            else
                st.still_count = 4'd0;
            if (st.still_count > STILL_TICKS)
            begin
                st.lift_phase  = lpss_pkg::LIFT_SPIKE;
                st.still_count = 4'd0;
            end
        end
        if (st.lift_phase == lpss_pkg::LIFT_SPIKE)
        begin
            st.lift_wait_count = st.lift_wait_count + 8'd1;
            if (st.lift_wait_count > LIFT_TIMEOUT)
            begin
                st.lift_wait_count = 8'd0;
                st.lift_phase      = lpss_pkg::LIFT_STILL;
            end
            if ((item.accel_z > LIFT_ACCEL_MIN) && lift_win)
                st.lift_phase = lpss_pkg::LIFT_SPIN;
        end
        if (st.lift_phase == lpss_pkg::LIFT_SPIN)
        begin
            st.spin_wait_count = st.spin_wait_count + 7'd1;
            if (st.spin_wait_count > SPIN_TIMEOUT)
            begin
                st.spin_wait_count = 7'd0;
                st.lift_phase      = lpss_pkg::LIFT_STILL;
            end
            if (spin_seen)
            begin
                st.lift_phase = lpss_pkg::LIFT_STILL;
                lifted        = 1'b1;
            end
        end
        if (lifted)
            stop = 1'b1;

        // Put-down detector, frozen while running.
        placed = 1'b0;
        if (stop)
        begin
            if (st.place_phase == lpss_pkg::PLACE_LEVEL)
            begin
                if (place_win && (item.left_count == 16'sd0) && (item.right_count == 16'sd0))
                    st.place_phase = lpss_pkg::PLACE_TURN;
            end
            if (st.place_phase == lpss_pkg::PLACE_TURN)
            begin
                st.place_wait_count = st.place_wait_count + 6'd1;
                if (st.place_wait_count > PLACE_TIMEOUT)
                begin
                    st.place_wait_count = 6'd0;
                    st.place_phase      = lpss_pkg::PLACE_LEVEL;
                end
                if (turn_seen)
                begin
                    st.place_phase = lpss_pkg::PLACE_LEVEL;
                    placed         = 1'b1;
                end
            end
        end
        if (placed)
            stop = 1'b0;

        // Mode selection from right-wheel turns while stopped.
        mode_sum = {7'd0, st.mode_turn_sum} + {1'b0, mag_r};
        if (!stop)
            st.mode_turn_sum = 10'd0;
        else if (item.left_count < MODE_HOLD_MAX)
        begin
            if ((mode_sum > MODE_NORMAL_LO) && (mode_sum < MODE_AVOID_LO))
            begin
                st.avoid_flag  = 1'b0;
                st.follow_flag = 1'b0;
            end
            if ((mode_sum > MODE_AVOID_LO) && (mode_sum < MODE_FOLLOW_LO))
            begin
                st.avoid_flag  = 1'b1;
                st.follow_flag = 1'b0;
            end
            if ((mode_sum > MODE_FOLLOW_LO) && (mode_sum < MODE_WRAP))
            begin
                st.avoid_flag  = 1'b0;
                st.follow_flag = 1'b1;
            end
            if (mode_sum > MODE_WRAP)
                mode_sum = 17'd0;
            st.mode_turn_sum = mode_sum[9:0];
        end

        // Drive enable from tilt limit, stop flag and battery minimum.
        tilt_n  = {item.tilt_angle[15], item.tilt_angle};
        limit_n = {2'b00, cfg.tilt_limit};
        fault   = (tilt_n < -limit_n) || (tilt_n > limit_n) || stop
               || (item.battery_level < cfg.battery_min);

        st.stop_flag = stop;
        state_next   = st;

        result.stopped      = stop;
        result.picked_up    = lifted;
        result.set_down     = placed;
        result.avoid_mode   = st.avoid_flag;
        result.follow_mode  = st.follow_flag;
        result.drive_enable = !fault;
    end

endmodule

`default_nettype wire

### hw/rtl/lift_place_safety_supervisor.sv
// Top level of the lift and place safety supervisor.
//
//  channel | direction | signals                      | contents
//  --------+-----------+------------------------------+-------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata    | one control tick, toggle in
//          |           | s_tuser                      | s_tuser
//  m_      | out       | m_tvalid m_tready m_tdata    | status flags for that tick
//  cfg_    | in        | cfg_wen cfg_index cfg_wdata  | configuration register writes
//
// Each tick passes from input transfer to result through the input register
// and then through the state update into the result register.
// One tick per cycle is accepted unless the result stalls; the state loop sets that.
// Reset clears all supervisor state and loads the register defaults.
// A stalled result holds the pipeline; the input side stays ready while the
// result register is empty or is being taken.
`default_nettype none

module lift_place_safety_supervisor (
    input  wire         clk,
    input  wire         rst_n,
    // accel_z[15:0], tilt_angle[31:16], left_count[47:32],
    // right_count[63:48], battery_level[79:64]
    input  wire  [79:0] s_tdata,
    // toggle_stop[0]
    input  wire         s_tuser,
    input  wire         s_tvalid,
    output logic        s_tready,
    // stopped[0], picked_up[1], set_down[2], avoid_mode[3], follow_mode[4],
    // drive_enable[5], zero[7:6]
    output logic [7:0]  m_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    input  wire         cfg_wen,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_wdata
);

    localparam logic signed [15:0] LEVEL_ANGLE_RST = 16'sd0;
    localparam logic        [14:0] TILT_LIMIT_RST  = 15'd4000;
    localparam logic        [15:0] BATTERY_MIN_RST = 16'd1110;

    lpss_pkg::lpss_cfg_t    cfg_reg;
    lpss_pkg::lpss_state_t  state_reg;
    lpss_pkg::lpss_state_t  state_next;
    lpss_pkg::lpss_item_t   s1_item_reg;
    logic                   s1_valid_reg;
    logic                   s1_valid_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [7:0]             m_data_reg;
    lpss_pkg::lpss_result_t result;
    lpss_pkg::lpss_item_t   in_item;
    logic                   out_free;
    logic                   s1_advance;
    logic                   in_xfer;

    // Handshake control for the two pipeline registers.
    assign out_free   = !m_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_tready   = !s1_valid_reg || out_free;
    assign in_xfer    = s_tvalid && s_tready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (s1_advance)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    // Unpack the incoming transfer.
    always_comb
    begin
        in_item.accel_z       = s_tdata[15:0];
        in_item.tilt_angle    = s_tdata[31:16];
        in_item.left_count    = s_tdata[47:32];
        in_item.right_count   = s_tdata[63:48];
        in_item.battery_level = s_tdata[79:64];
        in_item.toggle_stop   = s_tuser;
    end

    lpss_core u_core (
        .state      (state_reg),
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_angle <= LEVEL_ANGLE_RST;
            cfg_reg.tilt_limit  <= TILT_LIMIT_RST;
            cfg_reg.battery_min <= BATTERY_MIN_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                lpss_pkg::REG_LEVEL_ANGLE: cfg_reg.level_angle <= cfg_wdata;
                lpss_pkg::REG_TILT_LIMIT:  cfg_reg.tilt_limit  <= cfg_wdata[14:0];
                lpss_pkg::REG_BATTERY_MIN: cfg_reg.battery_min <= cfg_wdata;
                default:                   cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Control state: valid flags and supervisor state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg               <= 1'b0;
            m_valid_reg                <= 1'b0;
            state_reg.stop_flag        <= 1'b0;
            state_reg.lift_phase       <= lpss_pkg::LIFT_STILL;
            state_reg.still_count      <= 4'd0;
            state_reg.lift_wait_count  <= 8'd0;
            state_reg.spin_wait_count  <= 7'd0;
            state_reg.place_phase      <= lpss_pkg::PLACE_LEVEL;
            state_reg.place_wait_count <= 6'd0;
            state_reg.mode_turn_sum    <= 10'd0;
            state_reg.avoid_flag       <= 1'b0;
            state_reg.follow_flag      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            if (s1_advance)
                state_reg <= state_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            s1_item_reg <= in_item;
        if (s1_advance)
            m_data_reg <= {2'b00, result.drive_enable, result.follow_mode,
                           result.avoid_mode, result.set_down, result.picked_up,
                           result.stopped};
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

### hw/rtl/lpss_checker.sv
// Port-level checks for the lift and place safety supervisor, bound to the top level.
`default_nettype none

module lpss_checker (
    input wire        clk,
    input wire        rst_n,
    input wire [7:0]  m_tdata,
    input wire        m_tvalid,
    input wire        m_tready
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its flags.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // A stopped robot never has its drive enabled.
    a_stop_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> !m_tdata[5])
        else $error("drive enabled while stopped");

    // A put-down always leaves the robot running.
    a_put_down_runs: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> !m_tdata[0])
        else $error("stopped after put-down");

    // Avoid and follow modes exclude each other.
    a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[4]))
        else $error("avoid and follow both set");

endmodule

bind lift_place_safety_supervisor lpss_checker u_lpss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

### tb/lift_place_safety_supervisor_tb.sv
// Self-checking testbench for the lift and place safety supervisor.
`timescale 1ns / 100ps

module lift_place_safety_supervisor_tb;

    // Detector thresholds, tilt windows in hundredths of a degree.
    localparam int LIFT_ACCEL_MIN = 26000;
    localparam int STILL_SUM_MAX  = 30;
    localparam int STILL_TICKS    = 10;
    localparam int LIFT_TIMEOUT   = 200;
    localparam int SPIN_TIMEOUT   = 100;
    localparam int SPIN_SUM_MIN   = 70;
    localparam int LIFT_WINDOW    = 2000;
    localparam int PLACE_WINDOW   = 1000;
    localparam int PLACE_TIMEOUT  = 50;
    localparam int PLACE_TURN_MIN = 3;
    localparam int PLACE_TURN_MAX = 40;
    localparam int MODE_HOLD_MAX  = 10;
    localparam int MODE_NORMAL_LO = 6;
    localparam int MODE_AVOID_LO  = 180;
    localparam int MODE_FOLLOW_LO = 360;
    localparam int MODE_WRAP      = 540;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [79:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_wen = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    // Register copies used for prediction.
    logic signed [15:0] cfg_level = 16'sd0;
    logic        [14:0] cfg_tilt_lim = 15'd4000;
    logic        [15:0] cfg_batt_min = 16'd1110;

    // Supervisor state as the predictor sees it.
    bit                     stop_q = 1'b0;
    lpss_pkg::lift_phase_t  lift_ph = lpss_pkg::LIFT_STILL;
    int                     still_cnt = 0;
    int                     lift_wait = 0;
    int                     spin_wait = 0;
    lpss_pkg::place_phase_t place_ph = lpss_pkg::PLACE_LEVEL;
    int                     place_wait = 0;
    int                     turn_sum = 0;
    bit                     avoid_q = 1'b0;
    bit                     follow_q = 1'b0;

    lpss_pkg::lpss_result_t expected_flags[$];

    bit idle_on = 1'b1;
    int ready_hold = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_errors = 0;
    int n_lifts = 0;
    int n_places = 0;
    int n_settings = 1;

    lift_place_safety_supervisor i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Clock with a 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Signed random value in [lo, hi].
    function automatic int rnd(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int abs32(int v);
        return (v < 0) ? -v : v;
    endfunction

    // Idle length between transfers: mostly none or short, now and then long.
    function automatic int pick_gap();
        int p;
        if (!idle_on)
            return 0;
        p = rnd(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return rnd(1, 3);
        return rnd(8, 40);
    endfunction

    function automatic lpss_pkg::lpss_item_t make_tick(int az, int tilt, int l, int r,
                                                       int batt, bit tog);
        lpss_pkg::lpss_item_t t;
        t.accel_z       = 16'(az);
        t.tilt_angle    = 16'(tilt);
        t.left_count    = 16'(l);
        t.right_count   = 16'(r);
        t.battery_level = 16'(batt);
        t.toggle_stop   = tog;
        return t;
    endfunction

    // Background tick: no spike, tilt and battery often right at their limits.
    function automatic lpss_pkg::lpss_item_t base_tick();
        int lim;
        int tilt;
        int batt;
        lim = cfg_tilt_lim;
        if (rnd(0, 1) == 1)
            tilt = (rnd(0, 1) == 1 ? lim : -lim) + rnd(-2, 2);
        else
            tilt = rnd(-18000, 18000);
        if (rnd(0, 1) == 1)
        begin
            batt = int'(cfg_batt_min) + rnd(-2, 2);
            batt = (batt < 0) ? 0 : (batt > 65535) ? 65535 : batt;
        end
        else
            batt = rnd(0, 65535);
        return make_tick(rnd(-26000, 26000), tilt, rnd(-200, 200), rnd(-200, 200), batt, 1'b0);
    endfunction

    // Tick that cannot spin the wheels up or finish a put-down.
    function automatic lpss_pkg::lpss_item_t quiet_tick();
        lpss_pkg::lpss_item_t t;
        t = base_tick();
        t.left_count  = 16'sd0;
        t.right_count = 16'(rnd(-70, 70));
        return t;
    endfunction

    // Work out the flags for one accepted tick and queue them.
    task automatic predict_tick(input lpss_pkg::lpss_item_t t);
        int az;
        int tl;
        int l;
        int r;
        int lvl;
        int lim;
        int s;
        bit lifted;
        bit placed;
        bit fault;
        lpss_pkg::lpss_result_t res;
        az  = t.accel_z;
        tl  = t.tilt_angle;
        l   = t.left_count;
        r   = t.right_count;
        lvl = cfg_level;
        lim = cfg_tilt_lim;
        lifted = 1'b0;
        placed = 1'b0;

        if (t.toggle_stop)
            stop_q = !stop_q;

        // Pick-up: still wheels, then a spike near level, then a spin-up.
        if (lift_ph == lpss_pkg::LIFT_STILL)
        begin
            if (abs32(l) + abs32(r) < STILL_SUM_MAX)
                still_cnt++;
            else
                still_cnt = 0;
            if (still_cnt > STILL_TICKS)
            begin
                lift_ph = lpss_pkg::LIFT_SPIKE;
                still_cnt = 0;
            end
        end
        if (lift_ph == lpss_pkg::LIFT_SPIKE)
        begin
            lift_wait++;
            if (lift_wait > LIFT_TIMEOUT)
            begin
                lift_wait = 0;
                lift_ph = lpss_pkg::LIFT_STILL;
            end
            if (az > LIFT_ACCEL_MIN && tl > lvl - LIFT_WINDOW && tl < lvl + LIFT_WINDOW)
                lift_ph = lpss_pkg::LIFT_SPIN;
        end
        if (lift_ph == lpss_pkg::LIFT_SPIN)
        begin
            spin_wait++;
            if (spin_wait > SPIN_TIMEOUT)
            begin
                spin_wait = 0;
                lift_ph = lpss_pkg::LIFT_STILL;
            end
            if (abs32(l + r) > SPIN_SUM_MIN)
            begin
                lift_ph = lpss_pkg::LIFT_STILL;
                lifted = 1'b1;
            end
        end
        if (lifted)
            stop_q = 1'b1;

        // Put-down only runs while stopped.
        if (stop_q)
        begin
            if (place_ph == lpss_pkg::PLACE_LEVEL && tl > lvl - PLACE_WINDOW
                && tl < lvl + PLACE_WINDOW && l == 0 && r == 0)
                place_ph = lpss_pkg::PLACE_TURN;
            if (place_ph == lpss_pkg::PLACE_TURN)
            begin
                place_wait++;
                if (place_wait > PLACE_TIMEOUT)
                begin
                    place_wait = 0;
                    place_ph = lpss_pkg::PLACE_LEVEL;
                end
                if (l > PLACE_TURN_MIN && r > PLACE_TURN_MIN && l < PLACE_TURN_MAX
                    && r < PLACE_TURN_MAX)
                begin
                    place_ph = lpss_pkg::PLACE_LEVEL;
                    placed = 1'b1;
                end
            end
        end
        if (placed)
            stop_q = 1'b0;

        // Mode selection from right wheel turns while the left is held.
        if (!stop_q)
            turn_sum = 0;
        else if (l < MODE_HOLD_MAX)
        begin
            s = turn_sum + abs32(r);
            if (s > MODE_NORMAL_LO && s < MODE_AVOID_LO)
            begin
                avoid_q  = 1'b0;
                follow_q = 1'b0;
            end
            if (s > MODE_AVOID_LO && s < MODE_FOLLOW_LO)
            begin
                avoid_q  = 1'b1;
                follow_q = 1'b0;
            end
            if (s > MODE_FOLLOW_LO && s < MODE_WRAP)
            begin
                avoid_q  = 1'b0;
                follow_q = 1'b1;
            end
            if (s > MODE_WRAP)
                s = 0;
            turn_sum = s;
        end

        fault = tl < -lim || tl > lim || stop_q || t.battery_level < cfg_batt_min;

        res.stopped      = stop_q;
        res.picked_up    = lifted;
        res.set_down     = placed;
        res.avoid_mode   = avoid_q;
        res.follow_mode  = follow_q;
        res.drive_enable = !fault;
        expected_flags.push_back(res);
        n_lifts  += lifted;
        n_places += placed;
    endtask

    // Offer one tick and wait for its transfer.
    task automatic send_tick(input lpss_pkg::lpss_item_t t);
        int gap;
        s_tdata  <= {t.battery_level, t.right_count, t.left_count, t.tilt_angle, t.accel_z};
        s_tuser  <= t.toggle_stop;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_tick(t);
        n_sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and let every pending result come out.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_flags.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            lpss_pkg::REG_LEVEL_ANGLE: cfg_level    = val;
            lpss_pkg::REG_TILT_LIMIT:  cfg_tilt_lim = val[14:0];
            lpss_pkg::REG_BATTERY_MIN: cfg_batt_min = val;
            default: ;
        endcase
    endtask

    // Field extremes, tilt and battery limits, and a toggle on and off.
    task automatic test_field_extremes();
        send_tick(make_tick(-32768, -32768, -32768, -32768, 0, 1'b0));
        send_tick(make_tick(32767, 32767, 32767, 32767, 65535, 1'b0));
        send_tick(make_tick(0, -4000, 0, 0, 1110, 1'b0));
        send_tick(make_tick(0, 4000, 5, -5, 1110, 1'b0));
        send_tick(make_tick(0, 4001, 0, 0, 65535, 1'b0));
        send_tick(make_tick(0, -4001, 0, 0, 65535, 1'b0));
        send_tick(make_tick(0, 0, 0, 0, 1109, 1'b0));
        send_tick(make_tick(0, 0, -32768, 32767, 65535, 1'b1));
        send_tick(make_tick(-1, 18000, 32767, -32768, 65535, 1'b1));
        send_tick(make_tick(26000, -18000, 0, 0, 2000, 1'b0));
    endtask

    // A clean pick-up: still wheels, a spike at level, then a spin-up.
    task automatic test_pick_up();
        drain_results();
        repeat (STILL_TICKS + 1)
            send_tick(make_tick(0, 0, 0, 0, 2000, 1'b0));
        send_tick(make_tick(30000, 100, 0, 0, 2000, 1'b0));
        send_tick(make_tick(0, 0, 40, 40, 2000, 1'b0));
    endtask

    // Put down at level with still wheels, then a gentle forward turn.
    task automatic test_set_down();
        send_tick(make_tick(0, 0, 0, 0, 2000, 1'b0));
        send_tick(make_tick(0, 0, 10, 10, 2000, 1'b0));
        // While running the put-down detector must stay quiet.
        send_tick(make_tick(0, 0, 0, 0, 2000, 1'b0));
        send_tick(make_tick(0, 0, 10, 10, 2000, 1'b0));
    endtask

    // Walk the turn sum through normal, avoid, follow, wrap and the exact bounds.
    task automatic test_mode_select();
        send_tick(make_tick(0, 0, 0, 0, 2000, 1'b1));
        send_tick(make_tick(0, 0, 0, 100, 2000, 1'b0));
        send_tick(make_tick(0, 0, 0, -100, 2000, 1'b0));
        send_tick(make_tick(0, 0, 0, 200, 2000, 1'b0));
        send_tick(make_tick(0, 0, -5, 200, 2000, 1'b0));
        send_tick(make_tick(0, 0, 0, 180, 2000, 1'b0));
        send_tick(make_tick(0, 0, 0, 6, 2000, 1'b0));
        send_tick(make_tick(0, 0, 10, 500, 2000, 1'b0));
        send_tick(make_tick(0, 0, 0, 0, 2000, 1'b1));
    endtask

    // One random sequence: mostly well-formed detector runs, some noise.
    task automatic send_sequence();
        lpss_pkg::lpss_item_t t;
        int kind;
        int n;
        int tot;
        int l;
        int m;
        kind = rnd(0, 99);
        if (kind < 30)
        begin
            // Pick-up attempt, sometimes broken, sometimes left to time out.
            n = rnd(9, 14);
            repeat (n)
            begin
                t = base_tick();
                if (rnd(0, 19) != 0)
                begin
                    tot = rnd(0, STILL_SUM_MAX);
                    l = rnd(0, tot);
                    t.left_count  = 16'(rnd(0, 1) == 1 ? l : -l);
                    t.right_count = 16'(rnd(0, 1) == 1 ? tot - l : l - tot);
                end
                send_tick(t);
            end
            n = (rnd(0, 14) == 0) ? rnd(195, 215) : rnd(0, 8);
            repeat (n)
                send_tick(base_tick());
            t = base_tick();
            if (rnd(0, 9) != 0)
            begin
                t.accel_z    = 16'(rnd(LIFT_ACCEL_MIN, 32767));
                t.tilt_angle = 16'(int'(cfg_level) + rnd(-LIFT_WINDOW, LIFT_WINDOW));
            end
            send_tick(t);
            n = (rnd(0, 14) == 0) ? rnd(95, 110) : rnd(0, 5);
            repeat (n)
                send_tick(quiet_tick());
            t = base_tick();
            m = rnd(SPIN_SUM_MIN - 2, 300);
            l = rnd(0, m);
            t.left_count  = 16'(rnd(0, 1) == 1 ? l : -l);
            t.right_count = 16'(t.left_count < 0 ? l - m : m - l);
            send_tick(t);
        end
        else if (kind < 50)
        begin
            // Put-down attempt.
            t = base_tick();
            t.tilt_angle  = 16'(int'(cfg_level) + rnd(-PLACE_WINDOW, PLACE_WINDOW));
            t.left_count  = 16'sd0;
            t.right_count = 16'sd0;
            send_tick(t);
            n = (rnd(0, 9) == 0) ? rnd(48, 56) : rnd(0, 4);
            repeat (n)
                send_tick(quiet_tick());
            t = base_tick();
            t.left_count  = 16'(rnd(PLACE_TURN_MIN, PLACE_TURN_MAX));
            t.right_count = 16'(rnd(PLACE_TURN_MIN, PLACE_TURN_MAX));
            send_tick(t);
        end
        else if (kind < 70)
        begin
            // Mode selection run while stopped.
            if (!stop_q)
            begin
                t = base_tick();
                t.toggle_stop = 1'b1;
                send_tick(t);
            end
            n = rnd(3, 20);
            repeat (n)
            begin
                t = base_tick();
                t.left_count  = 16'(rnd(-20, MODE_HOLD_MAX));
                t.right_count = 16'(rnd(0, 9) == 0 ? rnd(-32768, 32767) : rnd(-250, 250));
                send_tick(t);
            end
        end
        else if (kind < 88)
        begin
            // Raw noise over the full width of every field.
            n = rnd(1, 6);
            repeat (n)
            begin
                t.accel_z       = 16'($urandom);
                t.tilt_angle    = 16'($urandom);
                t.left_count    = 16'($urandom);
                t.right_count   = 16'($urandom);
                t.battery_level = 16'($urandom);
                t.toggle_stop   = (rnd(0, 7) == 0);
                send_tick(t);
            end
        end
        else
        begin
            t = base_tick();
            t.toggle_stop = 1'b1;
            send_tick(t);
        end
        if (rnd(0, 39) == 0)
            drain_results();
    endtask

    // Random traffic under several register settings, extremes included.
    task automatic test_config_sweep();
        int lvl_set [6];
        int lim_set [6];
        int bat_set [6];
        int p;
        int start;
        lvl_set = '{0, -18000, 18000, 0, 18000, 0};
        lim_set = '{4000, 0, 18000, 4000, 0, 0};
        bat_set = '{1110, 0, 65535, 1110, 0, 0};
        for (p = 0; p < 7; p++)
        begin
            if (p > 0)
            begin
                if (p == 6)
                begin
                    write_reg(lpss_pkg::REG_LEVEL_ANGLE, 16'(rnd(-18000, 18000)));
                    write_reg(lpss_pkg::REG_TILT_LIMIT, 16'(rnd(0, 18000)));
                    write_reg(lpss_pkg::REG_BATTERY_MIN, 16'(rnd(0, 65535)));
                end
                else
                begin
                    write_reg(lpss_pkg::REG_LEVEL_ANGLE, 16'(lvl_set[p]));
                    write_reg(lpss_pkg::REG_TILT_LIMIT, 16'(lim_set[p]));
                    write_reg(lpss_pkg::REG_BATTERY_MIN, 16'(bat_set[p]));
                end
                n_settings++;
            end
            // One stretch runs with no idling on either side.
            idle_on = (p != 3);
            start = n_sent;
            while (n_sent - start < 175)
                send_sequence();
        end
        idle_on = 1'b1;
    endtask

    // Result side stalls: mostly ready, short and occasional long stalls.
    always @(posedge clk)
    begin : ready_stalls
        int p;
        if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            p = rnd(0, 99);
            if (!idle_on || p < 60)
                m_tready <= 1'b1;
            else
            begin
                m_tready   <= 1'b0;
                ready_hold <= (p < 92) ? rnd(0, 2) : rnd(8, 40);
            end
        end
    end

    function automatic void check_flag(string name, bit want, bit got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        lpss_pkg::lpss_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (expected_flags.size() == 0)
            begin
                $error("result transfer with no tick pending: m_tdata=%h", m_tdata);
                n_errors++;
            end
            else
            begin
                want = expected_flags.pop_front();
                check_flag("stopped", want.stopped, m_tdata[0]);
                check_flag("picked_up", want.picked_up, m_tdata[1]);
                check_flag("set_down", want.set_down, m_tdata[2]);
                check_flag("avoid_mode", want.avoid_mode, m_tdata[3]);
                check_flag("follow_mode", want.follow_mode, m_tdata[4]);
                check_flag("drive_enable", want.drive_enable, m_tdata[5]);
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_extremes();
        test_pick_up();
        test_set_down();
        test_mode_select();
        test_config_sweep();
        drain_results();
        repeat (10) @(posedge clk);
        $display("Run covered %0d ticks and %0d result transfers under %0d register settings,",
                 n_sent, n_results, n_settings);
        $display("with %0d pick-ups and %0d put-downs expected.", n_lifts, n_places);
        if (n_errors == 0)
            $display("lift_place_safety_supervisor_tb: clean");
        else
            $display("lift_place_safety_supervisor_tb: errors");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("lift_place_safety_supervisor_tb: errors");
        $finish;
    end

endmodule
